/* rtl/bhmt_pkg.sv */
// Shared types, constants and pattern tables of the binary hit/miss thinning pass.
// Depends on nothing; bhmt_front, bhmt_fifo, bhmt_back and the top import it.
`default_nettype none
package bhmt_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int RING_DEPTH = 8 * MAX_WIDTH;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int DIM_W      = 9;
  localparam int POS_W      = 17;
  localparam int CNT_W      = 17;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int WIN_N      = 5;

  localparam logic [1:0] MODE_SHRINK = 2'd0;
  localparam logic [1:0] MODE_THIN   = 2'd1;
  localparam logic [1:0] MODE_SKEL   = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int N_COND = 66;
  localparam int S_FIRST = 0;
  localparam int S_LAST = 57;
  localparam int T_FIRST = 16;
  localparam int T_LAST = 61;
  localparam int K_FIRST = 26;
  localparam int K_LAST = 65;
  localparam int N_ST_EXACT = 28;
  localparam int N_K_EXACT = 12;
  localparam int N_ST_OWN = 10;
  localparam int N_K_OWN = 6;
  localparam int N_SHARED = 32;

  typedef struct packed {
    logic [1:0]       mode;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } cfg_t;

  typedef struct packed {
    logic               en;
    logic [RING_AW-1:0] addr;
    logic               data;
  } ring_wr_t;

  localparam logic [8:0] COND_TAB [0:N_COND-1] = '{
    9'o120, 9'o420, 9'o024, 9'o021, 9'o030, 9'o220, 9'o060, 9'o022,
    9'o130, 9'o320, 9'o620, 9'o460, 9'o064, 9'o026, 9'o023, 9'o031,
    9'o630, 9'o231, 9'o360, 9'o132, 9'o330, 9'o660, 9'o066, 9'o033,
    9'o631, 9'o364,
    9'o333, 9'o770, 9'o666, 9'o077, 9'o733, 9'o337, 9'o774, 9'o771,
    9'o766, 9'o667, 9'o477, 9'o177, 9'o737, 9'o775, 9'o767, 9'o577,
    9'o131, 9'o720, 9'o464, 9'o027, 9'o730, 9'o331, 9'o760, 9'o664,
    9'o466, 9'o067, 9'o037, 9'o133, 9'o731, 9'o764, 9'o467, 9'o137,
    9'o230, 9'o260, 9'o062, 9'o032, 9'o773, 9'o776, 9'o677, 9'o377
  };

  localparam logic [8:0] ST_EXACT [0:N_ST_EXACT-1] = '{
    9'o120, 9'o420, 9'o022, 9'o030, 9'o130, 9'o320, 9'o620, 9'o460,
    9'o064, 9'o026, 9'o023, 9'o031, 9'o360, 9'o630, 9'o231, 9'o132,
    9'o334, 9'o134, 9'o324, 9'o661, 9'o461, 9'o621, 9'o166, 9'o164,
    9'o126, 9'o433, 9'o431, 9'o423
  };

  localparam logic [8:0] K_EXACT [0:N_K_EXACT-1] = '{
    9'o021, 9'o024, 9'o120, 9'o420, 9'o022, 9'o030, 9'o060, 9'o220,
    9'o230, 9'o260, 9'o032, 9'o062
  };

  localparam logic [8:0] ST_OWN_VAL [0:N_ST_OWN-1] = '{
    9'o660, 9'o033, 9'o270, 9'o270, 9'o072, 9'o072, 9'o262, 9'o262, 9'o232, 9'o232
  };
  localparam logic [8:0] ST_OWN_MSK [0:N_ST_OWN-1] = '{
    9'o660, 9'o033, 9'o373, 9'o676, 9'o676, 9'o373, 9'o277, 9'o772, 9'o772, 9'o277
  };

  localparam logic [8:0] K_OWN_VAL [0:N_K_OWN-1] = '{
    9'o660, 9'o033, 9'o270, 9'o262, 9'o072, 9'o232
  };

  localparam logic [8:0] SH_VAL [0:N_SHARED-1] = '{
    9'o521, 9'o522, 9'o523, 9'o524, 9'o525, 9'o526, 9'o527,
    9'o425, 9'o434, 9'o435, 9'o524, 9'o525, 9'o534, 9'o535,
    9'o125, 9'o225, 9'o325, 9'o425, 9'o525, 9'o625, 9'o725,
    9'o125, 9'o161, 9'o165, 9'o521, 9'o525, 9'o561, 9'o565,
    9'o234, 9'o261, 9'o162, 9'o432
  };
  localparam logic [8:0] SH_MSK [0:N_SHARED-1] = '{
    9'o527, 9'o527, 9'o527, 9'o527, 9'o527, 9'o527, 9'o527,
    9'o535, 9'o535, 9'o535, 9'o535, 9'o535, 9'o535, 9'o535,
    9'o725, 9'o725, 9'o725, 9'o725, 9'o725, 9'o725, 9'o725,
    9'o565, 9'o565, 9'o565, 9'o565, 9'o565, 9'o565, 9'o565,
    9'o376, 9'o673, 9'o376, 9'o673
  };

  // Conditional mark: window matches an entry of the mode's table range.
  function automatic logic cond_hit(input logic [8:0] p, input logic [1:0] mode);
    int lo;
    int hi;
    logic hit;
    lo  = 0;
    hi  = -1;
    hit = 1'b0;
    case (mode)
      MODE_SHRINK: begin
        lo = S_FIRST;
        hi = S_LAST;
      end
      MODE_THIN: begin
        lo = T_FIRST;
        hi = T_LAST;
      end
      MODE_SKEL: begin
        lo = K_FIRST;
        hi = K_LAST;
      end
      default: begin
        lo = 0;
        hi = -1;
      end
    endcase
    for (int i = 0; i < N_COND; i++) begin
      if (i >= lo && i <= hi && p == COND_TAB[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  // Unconditional hit: exact or masked match in the mode's table set.
  function automatic logic uncond_hit(input logic [8:0] p, input logic [1:0] mode);
    logic hit;
    hit = 1'b0;
    if (mode == MODE_SKEL) begin
      for (int i = 0; i < N_K_EXACT; i++) if (p == K_EXACT[i]) hit = 1'b1;
      for (int i = 0; i < N_K_OWN; i++) if ((p & K_OWN_VAL[i]) == K_OWN_VAL[i]) hit = 1'b1;
    end else begin
      for (int i = 0; i < N_ST_EXACT; i++) if (p == ST_EXACT[i]) hit = 1'b1;
      for (int i = 0; i < N_ST_OWN; i++) begin
        if ((p & ST_OWN_MSK[i]) == ST_OWN_VAL[i]) hit = 1'b1;
      end
    end
    for (int i = 0; i < N_SHARED; i++) if ((p & SH_MSK[i]) == SH_VAL[i]) hit = 1'b1;
    return hit;
  endfunction

endpackage
`default_nettype wire

/* rtl/bhmt_ram.sv */
// Generic single-write, single-read RAM with registered, enabled read data.
// Depends on nothing.
`default_nettype none
module bhmt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem_r[rd_addr];
  end
endmodule
`default_nettype wire

/* rtl/bhmt_front.sv */
// Input side: takes pixel and flush beats, writes pixels to the ring and
// releases one result token per beat once its neighborhood has arrived. Uses bhmt_pkg.
`default_nettype none
module bhmt_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire bhmt_pkg::cfg_t       cfg,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_pixel_in,
  input  wire logic                 in_flush,
  input  wire logic                 q_full,
  output logic                      tok_push,
  output logic                      tok_last,
  output bhmt_pkg::ring_wr_t        ring_wr
);
  import bhmt_pkg::*;

  logic [RING_AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [RING_AW-1:0] pend_r, pend_nxt, pend1;
  logic [POS_W-1:0]   k_r, k_nxt;
  logic [POS_W-1:0]   n_pix, rem, need, lim;
  logic               acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    n_pix = POS_W'(cfg.w) * POS_W'(cfg.h);
    rem   = n_pix - k_r;
    lim   = (POS_W'(cfg.w) << 1) + POS_W'(3);
    need  = (rem < lim) ? rem : lim;
    pend1 = pend_r + RING_AW'(!in_flush);
    tok_push = acc && (pend1 != '0) && (POS_W'(pend1) >= need);
    tok_last = (rem == POS_W'(1));

    pend_nxt   = pend_r;
    k_nxt      = k_r;
    wr_pos_nxt = wr_pos_r;
    if (acc) begin
      pend_nxt = tok_push ? pend1 - RING_AW'(1) : pend1;
      if (!in_flush) wr_pos_nxt = wr_pos_r + RING_AW'(1);
    end
    if (tok_push) k_nxt = tok_last ? '0 : k_r + POS_W'(1);

    ring_wr.en   = acc && !in_flush;
    ring_wr.addr = wr_pos_r;
    ring_wr.data = in_pixel_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      wr_pos_r <= '0;
      pend_r   <= '0;
      k_r      <= '0;
    end else begin
      wr_pos_r <= wr_pos_nxt;
      pend_r   <= pend_nxt;
      k_r      <= k_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/bhmt_fifo.sv */
// Short token queue between the front and back; each entry is the frame-last flag.
// Uses bhmt_pkg.
`default_nettype none
module bhmt_fifo (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic clr,
  input  wire logic push,
  input  wire logic push_last,
  input  wire logic pop,
  output logic      avail,
  output logic      head_last,
  output logic      full
);
  import bhmt_pkg::*;

  logic               mem_r [0:FIFO_DEPTH-1];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign avail     = (cnt_r != '0);
  assign full      = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign head_last = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    if (pop && !push) cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_last;
    if (!rst_n || clr) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + FIFO_AW'(1);
      if (pop) rp_r <= rp_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/bhmt_back.sv */
// Result side: reads five ring rows per token, builds the 5x5 window, marks the
// 3x3 candidate mask, applies the unconditional tables and counts erasures.
// Uses bhmt_pkg and bhmt_ram.
`default_nettype none
module bhmt_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       clr,
  input  wire bhmt_pkg::cfg_t             cfg,
  input  wire bhmt_pkg::ring_wr_t         ring_wr,
  input  wire logic                       tok_avail,
  input  wire logic                       tok_last,
  output logic                            tok_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            out_pixel_out,
  output logic                            out_erased,
  output logic                            out_frame_last,
  output logic [bhmt_pkg::CNT_W-1:0]      out_erased_total
);
  import bhmt_pkg::*;

  localparam logic [1:0] PRIME_DONE = 2'd2;

  logic               adv, fire;
  logic [RING_AW-1:0] ptr_r, ptr_nxt;
  logic [1:0]         prime_r, prime_nxt;
  logic [DIM_W-1:0]   orow_r, orow_nxt, ocol_r, ocol_nxt;
  logic [RING_AW-1:0] w_a;
  logic [RING_AW-1:0] rd_addr [0:WIN_N-1];
  logic               rd_data [0:WIN_N-1];

  logic               v1_r, e1_r, l1_r;
  logic [DIM_W-1:0]   r1_r, c1_r;
  logic [WIN_N-1:0]   win_r [0:WIN_N-1];
  logic               v2_r, l2_r;
  logic [DIM_W-1:0]   r2_r, c2_r;
  logic               v3_r, l3_r, ctr3_r;
  logic [8:0]         m3_r;
  logic               out_valid_r, pix_r, ers_r, last_r;
  logic [CNT_W-1:0]   tot_r, cnt_r, cnt_sum;

  logic [WIN_N-1:0]   row_ok, col_ok;
  logic [WIN_N-1:0]   z [0:WIN_N-1];
  logic [8:0]         mask9, pat;
  logic               erase3;

  assign adv     = !out_valid_r || !out_stall;
  assign fire    = adv && tok_avail;
  assign tok_pop = fire && (prime_r == PRIME_DONE);

  // Row a of the window sits (a-2) image rows from the read pointer.
  assign w_a        = RING_AW'(cfg.w);
  assign rd_addr[0] = ptr_r - (w_a << 1);
  assign rd_addr[1] = ptr_r - w_a;
  assign rd_addr[2] = ptr_r;
  assign rd_addr[3] = ptr_r + w_a;
  assign rd_addr[4] = ptr_r + (w_a << 1);

  for (genvar a = 0; a < WIN_N; a++) begin : g_row
    bhmt_ram #(.WIDTH(1), .DEPTH(RING_DEPTH)) u_ram (
      .clk     (clk),
      .wr_en   (ring_wr.en),
      .wr_addr (ring_wr.addr),
      .wr_data (ring_wr.data),
      .rd_en   (adv),
      .rd_addr (rd_addr[a]),
      .rd_data (rd_data[a])
    );
  end

  always_comb begin
    ptr_nxt   = ptr_r;
    prime_nxt = prime_r;
    orow_nxt  = orow_r;
    ocol_nxt  = ocol_r;
    if (fire) begin
      ptr_nxt = ptr_r + RING_AW'(1);
      if (prime_r != PRIME_DONE) prime_nxt = prime_r + 2'd1;
    end
    if (tok_pop) begin
      if (tok_last) begin
        // next frame starts one behind the current read position
        ptr_nxt   = ptr_r - RING_AW'(1);
        prime_nxt = '0;
        orow_nxt  = '0;
        ocol_nxt  = '0;
      end else if ((DIM_W+1)'(ocol_r) + (DIM_W+1)'(1) >= (DIM_W+1)'(cfg.w)) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + DIM_W'(1);
      end else begin
        ocol_nxt = ocol_r + DIM_W'(1);
      end
    end
  end

  // Zero padding by true coordinates, candidate mask around the centre.
  always_comb begin
    row_ok[0] = (r2_r >= DIM_W'(2));
    row_ok[1] = (r2_r >= DIM_W'(1));
    row_ok[2] = 1'b1;
    row_ok[3] = ((DIM_W+1)'(r2_r) + (DIM_W+1)'(1)) < (DIM_W+1)'(cfg.h);
    row_ok[4] = ((DIM_W+1)'(r2_r) + (DIM_W+1)'(2)) < (DIM_W+1)'(cfg.h);
    col_ok[0] = (c2_r >= DIM_W'(2));
    col_ok[1] = (c2_r >= DIM_W'(1));
    col_ok[2] = 1'b1;
    col_ok[3] = ((DIM_W+1)'(c2_r) + (DIM_W+1)'(1)) < (DIM_W+1)'(cfg.w);
    col_ok[4] = ((DIM_W+1)'(c2_r) + (DIM_W+1)'(2)) < (DIM_W+1)'(cfg.w);
    for (int a = 0; a < WIN_N; a++) begin
      for (int j = 0; j < WIN_N; j++) z[a][j] = win_r[a][j] & row_ok[a] & col_ok[j];
    end
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        pat = {z[dr][dc], z[dr][dc+1], z[dr][dc+2],
               z[dr+1][dc], z[dr+1][dc+1], z[dr+1][dc+2],
               z[dr+2][dc], z[dr+2][dc+1], z[dr+2][dc+2]};
        mask9[8 - (dr*3 + dc)] = row_ok[dr+1] & col_ok[dc+1] & cond_hit(pat, cfg.mode);
      end
    end
  end

  assign erase3  = m3_r[4] && !uncond_hit(m3_r, cfg.mode);
  assign cnt_sum = (erase3 && cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r <= orow_r;
      c1_r <= ocol_r;
      l1_r <= tok_last;
      r2_r <= r1_r;
      c2_r <= c1_r;
      l2_r <= l1_r;
      m3_r   <= mask9;
      ctr3_r <= z[2][2];
      l3_r   <= l2_r;
      if (v1_r) begin
        for (int a = 0; a < WIN_N; a++) win_r[a] <= {rd_data[a], win_r[a][WIN_N-1:1]};
      end
      if (v3_r) begin
        pix_r  <= ctr3_r && !erase3;
        ers_r  <= erase3;
        last_r <= l3_r;
        tot_r  <= cnt_sum;
      end
    end
    if (!rst_n || clr) begin
      ptr_r       <= '0;
      prime_r     <= '0;
      orow_r      <= '0;
      ocol_r      <= '0;
      v1_r        <= 1'b0;
      e1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      ptr_r   <= ptr_nxt;
      prime_r <= prime_nxt;
      orow_r  <= orow_nxt;
      ocol_r  <= ocol_nxt;
      if (adv) begin
        v1_r        <= fire;
        e1_r        <= tok_pop;
        v2_r        <= v1_r && e1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
        if (v3_r) cnt_r <= l3_r ? '0 : cnt_sum;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_out    = pix_r;
  assign out_erased       = ers_r;
  assign out_frame_last   = last_r;
  assign out_erased_total = tot_r;
endmodule
`default_nettype wire

/* rtl/binary_hit_miss_thinning_pass_top.sv */
// Top level of the binary hit/miss thinning pass: configuration registers,
// front, token queue and back. Uses bhmt_pkg, bhmt_front, bhmt_fifo, bhmt_back.
`default_nettype none
// One pass of shrinking, thinning or skeletonizing over a raster stream of
// one-bit pixels, one beat per clock while neither side stalls. Each input beat
// (pixel or flush) releases at most one result beat, for the oldest pixel whose
// 5x5 neighborhood has arrived (2*W+2 pixels later, or at frame end); flush
// beats and the next frame's pixels push out the tail of a frame. The five ring
// RAMs (one read port each, one per window row) set the one-beat-per-clock
// rate, and extra back-end reads prime each frame's window. A mode, width or
// height write restarts framing, drops pending results and clears the erase
// count.
module binary_hit_miss_thinning_pass_top (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [bhmt_pkg::DIM_W-1:0] cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_pixel_in,
  input  wire logic                     in_flush,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_pixel_out,
  output logic                          out_erased,
  output logic                          out_frame_last,
  output logic [bhmt_pkg::CNT_W-1:0]    out_erased_total
);
  import bhmt_pkg::*;

  logic [1:0]       mode_r;
  logic [DIM_W-1:0] width_r, height_r;
  logic             clr;
  cfg_t             cfg;
  ring_wr_t         ring_wr;
  logic             tok_push, tok_last_in, tok_pop, tok_avail, tok_last, q_full;

  // Any write to a known register restarts the stream.
  assign clr = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_WIDTH ||
                          cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_THIN;
      width_r  <= DIM_W'(MAX_WIDTH);
      height_r <= DIM_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r   <= cfg_wdata[1:0];
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp width to 1..MAX_WIDTH and height to at least 1.
  always_comb begin
    cfg.mode = mode_r;
    if (width_r == '0) cfg.w = DIM_W'(1);
    else if (width_r > DIM_W'(MAX_WIDTH)) cfg.w = DIM_W'(MAX_WIDTH);
    else cfg.w = width_r;
    cfg.h = (height_r == '0) ? DIM_W'(1) : height_r;
  end

  bhmt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clr         (clr),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .in_flush    (in_flush),
    .q_full      (q_full),
    .tok_push    (tok_push),
    .tok_last    (tok_last_in),
    .ring_wr     (ring_wr)
  );

  bhmt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (clr),
    .push      (tok_push),
    .push_last (tok_last_in),
    .pop       (tok_pop),
    .avail     (tok_avail),
    .head_last (tok_last),
    .full      (q_full)
  );

  bhmt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clr              (clr),
    .cfg              (cfg),
    .ring_wr          (ring_wr),
    .tok_avail        (tok_avail),
    .tok_last         (tok_last),
    .tok_pop          (tok_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel_out    (out_pixel_out),
    .out_erased       (out_erased),
    .out_frame_last   (out_frame_last),
    .out_erased_total (out_erased_total)
  );
endmodule
`default_nettype wire
